// ===== rtl/sha256_byte_stream_hasher_top_defines.svh =====
// Assertion macros shared by the checker files of the SHA-256 byte stream hasher.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHAB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHAB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/shab_pkg.sv =====
// Types, constants and round functions of the SHA-256 byte stream hasher.
// Depends on nothing; used by every module of the block.
package shab_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int CHAIN_WORDS = 8;
	localparam int COUNT_W = 61;
	localparam int FILL_W = 6;
	localparam int ROUND_W = 6;
	localparam int IDX_W = 3;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [FILL_W-1:0] FILL_PAD_LIMIT = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
	localparam logic [IDX_W-1:0] WORD_LAST = 3'd7;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} msg_t;

	typedef struct packed {
		logic [31:0]      digest_word;
		logic [IDX_W-1:0] word_index;
		logic             final_word;
	} dig_t;

	typedef struct packed {
		logic               load;
		logic               put_byte;
		logic               put_pad;
		logic               put_len;
		logic               comp_init;
		logic               comp_round;
		logic               comp_finish;
		logic               emit;
		logic               restart;
		logic [ROUND_W-1:0] round;
		logic [IDX_W-1:0]   word_idx;
	} cmd_t;

	typedef struct packed {
		logic present;
		logic last;
		logic fill_last;
		logic fill_high;
		logic out_busy;
	} stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
		logic [63:0] d;
		d = {v, v} >> s;
		return d[31:0];
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/shab_datapath.sv =====
// Datapath of the SHA-256 byte stream hasher: block buffer, chaining words,
// round registers, byte counter and the digest output register. Uses shab_pkg.
module shab_datapath
	import shab_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  msg_t  msg,
	input  cmd_t  cmd,
	output stat_t stat,
	output dig_t  dig,
	output logic  dig_valid,
	input  logic  dig_stall
);

	logic [31:0]        blk_q [BLOCK_WORDS];
	logic [31:0]        chain_q [CHAIN_WORDS];
	logic [31:0]        wv_q [CHAIN_WORDS];
	logic [COUNT_W-1:0] count_q;
	logic [FILL_W-1:0]  fill_q;
	msg_t               msg_q;
	dig_t               dig_q;
	logic               dig_valid_q;

	logic [7:0]  put_val;
	logic [3:0]  widx;
	logic [4:0]  sh;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_next;

	always_comb begin
		put_val = cmd.put_pad ? PAD_BYTE : msg_q.data_byte;
		widx = fill_q[5:2];
		sh = {~fill_q[1:0], 3'b000};
		ch = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t1 = wv_q[7] + big_sig1(wv_q[4]) + ch + ROUND_K[cmd.round] + blk_q[0];
		t2 = big_sig0(wv_q[0]) + maj;
		w_next = small_sig1(blk_q[14]) + blk_q[9] + small_sig0(blk_q[1]) + blk_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				blk_q[i] <= '0;
			end
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
			count_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.comp_finish) begin
				for (int i = 0; i < CHAIN_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + wv_q[i];
				end
				for (int i = 0; i < BLOCK_WORDS; i++) begin
					blk_q[i] <= '0;
				end
			end else if (cmd.comp_round) begin
				for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
					blk_q[i] <= blk_q[i+1];
				end
				blk_q[BLOCK_WORDS-1] <= w_next;
			end else if (cmd.put_len) begin
				blk_q[14] <= count_q[60:29];
				blk_q[15] <= {count_q[28:0], 3'b000};
			end else if (cmd.put_byte || cmd.put_pad) begin
				blk_q[widx][sh +: 8] <= put_val;
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.put_byte) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.restart) begin
				for (int i = 0; i < CHAIN_WORDS; i++) begin
					chain_q[i] <= H_INIT[i];
				end
				count_q <= '0;
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			msg_q <= msg;
		end
		if (cmd.comp_init) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (cmd.comp_round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
		if (cmd.emit) begin
			dig_q.digest_word <= chain_q[cmd.word_idx];
			dig_q.word_index <= cmd.word_idx;
			dig_q.final_word <= (cmd.word_idx == WORD_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			dig_valid_q <= 1'b1;
		end else if (!dig_stall) begin
			dig_valid_q <= 1'b0;
		end
	end

	assign stat.present = msg_q.byte_present;
	assign stat.last = msg_q.message_end;
	assign stat.fill_last = (fill_q == FILL_LAST);
	assign stat.fill_high = (fill_q >= FILL_PAD_LIMIT);
	assign stat.out_busy = dig_valid_q & dig_stall;
	assign dig = dig_q;
	assign dig_valid = dig_valid_q;

endmodule

// ===== rtl/shab_ctrl.sv =====
// Controller of the SHA-256 byte stream hasher: sequences byte writes, padding,
// compression rounds and digest output. Uses shab_pkg.
module shab_ctrl
	import shab_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  msg_valid,
	output logic  msg_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUT,
		ST_AFTER,
		ST_PAD,
		ST_LEN,
		ST_INIT,
		ST_ROUND,
		ST_FINISH,
		ST_OUT
	} state_t;

	state_t             state_q;
	state_t             ret_q;
	logic [ROUND_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (stat.present && stat.fill_last) begin
						state_q <= ST_INIT;
						ret_q <= ST_AFTER;
					end else if (stat.last) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_AFTER: begin
					state_q <= stat.last ? ST_PAD : ST_IDLE;
				end
				ST_PAD: begin
					if (stat.fill_high) begin
						state_q <= ST_INIT;
						ret_q <= ST_LEN;
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					state_q <= ST_INIT;
					ret_q <= ST_OUT;
				end
				ST_INIT: begin
					cnt_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROUND_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					cnt_q <= '0;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (!stat.out_busy) begin
						if (cnt_q[IDX_W-1:0] == WORD_LAST) begin
							cnt_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.round = cnt_q;
		cmd.word_idx = cnt_q[IDX_W-1:0];
		cmd.load = (state_q == ST_IDLE) && msg_valid;
		cmd.put_byte = (state_q == ST_PUT) && stat.present;
		cmd.put_pad = (state_q == ST_PAD);
		cmd.put_len = (state_q == ST_LEN);
		cmd.comp_init = (state_q == ST_INIT);
		cmd.comp_round = (state_q == ST_ROUND);
		cmd.comp_finish = (state_q == ST_FINISH);
		cmd.emit = (state_q == ST_OUT) && !stat.out_busy;
		cmd.restart = cmd.emit && (cnt_q[IDX_W-1:0] == WORD_LAST);
	end

	assign msg_stall = (state_q != ST_IDLE);

endmodule

// ===== rtl/sha256_byte_stream_hasher_top.sv =====
// Byte request: loaded in idle, stored in put; each full 64-byte block is then compressed.
// End of message: pad and length states, one compression per remaining block (one or two),
// then eight digest words from a registered output, one per cycle when not stalled.
// The next message request is accepted as soon as the last word sits in the output register.
// Reset is asynchronous and active low: chaining words go to the initial hash values,
// the block buffer, byte count and fill clear at once, with no clearing pass.
module sha256_byte_stream_hasher_top
	import shab_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic dig_valid,
	input  logic dig_stall,
	output dig_t dig
);

	cmd_t  cmd;
	stat_t stat;

	shab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	shab_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cmd       (cmd),
		.stat      (stat),
		.dig       (dig),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall)
	);

endmodule

// ===== rtl/shab_checker.sv =====
// Port-level checker for the SHA-256 byte stream hasher and its bind to the top level.
// Depends on shab_pkg and sha256_byte_stream_hasher_top_defines.svh.
`include "sha256_byte_stream_hasher_top_defines.svh"

module shab_checker
	import shab_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic msg_valid,
	input logic msg_stall,
	input msg_t msg,
	input logic dig_valid,
	input logic dig_stall,
	input dig_t dig
);

	`SHAB_ASSERT_NEXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(dig), "stalled digest request changed")
	`SHAB_ASSERT_NOW(a_final_flag, dig_valid, dig.final_word == (dig.word_index == WORD_LAST), "final_word does not match word_index")
	`SHAB_ASSERT_NEXT(a_end_busy, msg_valid && !msg_stall && msg.message_end, msg_stall, "message end request did not start hashing")
	`SHAB_ASSERT_NOW(a_emit_busy, dig_valid && !dig.final_word, msg_stall, "input open before last word")

endmodule

bind sha256_byte_stream_hasher_top shab_checker u_shab_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the SHA-256 byte stream hasher: drives byte requests,
// predicts each digest word and checks every word the block returns.
// Depends on shab_pkg and sha256_byte_stream_hasher_top.
`timescale 1ns / 100ps

module tb_top;
	import shab_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int REQ_TARGET = 480;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_stall;
	msg_t msg = '0;
	logic dig_valid;
	logic dig_stall = 1'b0;
	dig_t dig;

	msg_t request_q[$];
	dig_t digest_q[$];
	int send_gap = 0;
	int stall_cnt = 0;
	int stall_draw;
	int cycle_cnt = 0;
	int fail_cnt = 0;
	int req_total = 0;
	dig_t exp_word;

	logic [31:0] blk_words [16];
	logic [31:0] hash_state [8];
	logic [60:0] len_bytes;
	logic [5:0] blk_fill;

	sha256_byte_stream_hasher_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg(msg),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.dig(dig)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int draw_wait();
		return ((cycle_cnt / 3000) % 3 == 0) ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic restart_message();
		foreach (blk_words[i]) blk_words[i] = '0;
		foreach (hash_state[i]) hash_state[i] = SHA_IV[i];
		len_bytes = '0;
		blk_fill = '0;
	endtask

	task automatic run_rounds();
		logic [31:0] sch [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x, y;
		for (int i = 0; i < 16; i++)
			sch[i] = blk_words[i];
		for (int i = 16; i < 64; i++) begin
			x = sch[i-15];
			y = sch[i-2];
			sch[i] = sch[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + sch[i-7]
				+ (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
		end
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		f = hash_state[5];
		g = hash_state[6];
		h = hash_state[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[i] + sch[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
		hash_state[5] += f;
		hash_state[6] += g;
		hash_state[7] += h;
		foreach (blk_words[i]) blk_words[i] = '0;
	endtask

	task automatic absorb_byte(input logic [7:0] value);
		int sh;
		sh = (3 - int'(blk_fill[1:0])) * 8;
		blk_words[blk_fill[5:2]] = blk_words[blk_fill[5:2]] | (32'(value) << sh);
		if (blk_fill == 6'd63) begin
			run_rounds();
			blk_fill = '0;
		end else begin
			blk_fill = blk_fill + 6'd1;
		end
	endtask

	task automatic predict_digest(input msg_t m);
		logic [63:0] bit_len;
		dig_t word;
		if (m.byte_present) begin
			absorb_byte(m.data_byte);
			len_bytes = len_bytes + 61'd1;
		end
		if (m.message_end) begin
			bit_len = {len_bytes, 3'b000};
			absorb_byte(PAD_MARK);
			if (blk_fill > 6'd56)
				run_rounds();
			blk_words[14] = bit_len[63:32];
			blk_words[15] = bit_len[31:0];
			run_rounds();
			for (int i = 0; i < 8; i++) begin
				word.digest_word = hash_state[i];
				word.word_index = 3'(i);
				word.final_word = (i == 7);
				digest_q = {digest_q, word};
			end
			restart_message();
		end
	endtask

	task automatic push_req(input logic [7:0] value, input logic present, input logic last);
		msg_t m;
		m.data_byte = value;
		m.byte_present = present;
		m.message_end = last;
		request_q = {request_q, m};
		if (present || last)
			req_total++;
	endtask

	task automatic queue_message(input int n_bytes);
		bit end_alone;
		end_alone = (n_bytes == 0) || ($urandom_range(0, 1) == 0);
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_req(8'($urandom_range(0, 255)), 1'b1, !end_alone && (i == n_bytes - 1));
		end
		if (end_alone)
			push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic build_stimulus();
		int n;
		int edge_lens [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
		push_req(8'h00, 1'b0, 1'b1);
		push_req(8'hff, 1'b0, 1'b0);
		push_req(8'h61, 1'b1, 1'b0);
		push_req(8'h62, 1'b1, 1'b0);
		push_req(8'h63, 1'b1, 1'b1);
		push_req(8'h00, 1'b1, 1'b0);
		push_req(8'hff, 1'b1, 1'b0);
		push_req(8'h00, 1'b0, 1'b0);
		push_req(8'ha5, 1'b0, 1'b1);
		push_req(8'hff, 1'b1, 1'b1);
		push_req(8'h00, 1'b1, 1'b1);
		push_req(8'h5a, 1'b0, 1'b1);
		while (req_total < REQ_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				n = edge_lens[$urandom_range(0, 9)];
			else
				n = $urandom_range(0, 24);
			queue_message(n);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid <= 1'b0;
			msg <= '0;
			send_gap <= draw_wait();
		end else begin
			if (msg_valid && !msg_stall)
				predict_digest(msg);
			if (!msg_valid || !msg_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					msg_valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					msg <= request_q.pop_front();
					msg_valid <= 1'b1;
					send_gap <= draw_wait();
				end else begin
					msg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_stall <= 1'b0;
			stall_cnt <= 0;
		end else if (dig_valid && !dig_stall) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h", dig.digest_word);
				fail_cnt++;
			end else begin
				exp_word = digest_q.pop_front();
				if (dig.digest_word !== exp_word.digest_word) begin
					$error("digest_word expected %h actual %h",
						exp_word.digest_word, dig.digest_word);
					fail_cnt++;
				end
				if (dig.word_index !== exp_word.word_index) begin
					$error("word_index expected %0d actual %0d",
						exp_word.word_index, dig.word_index);
					fail_cnt++;
				end
				if (dig.final_word !== exp_word.final_word) begin
					$error("final_word expected %0d actual %0d",
						exp_word.final_word, dig.final_word);
					fail_cnt++;
				end
			end
			stall_draw = draw_wait();
			stall_cnt <= stall_draw;
			dig_stall <= (stall_draw != 0);
		end else if (stall_cnt > 1) begin
			stall_cnt <= stall_cnt - 1;
		end else begin
			stall_cnt <= 0;
			dig_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		restart_message();
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (request_q.size() != 0 || msg_valid || digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
